// ----- rtl/fsq_pkg.sv -----
// Package for the radix 2^51 field squaring pipeline (p = 2^255 - 19).
// Holds the widths, the fold constant and the shared limb types; no dependencies.
package fsq_pkg;

  localparam int unsigned NUM_LIMBS  = 5;
  localparam int unsigned NUM_PRODS  = 15;
  localparam int unsigned LIMB_IN_W  = 54;
  localparam int unsigned LIMB_W     = 51;
  localparam int unsigned LIMB1_W    = 52;
  // 19 times a 54-bit limb needs 59 bits.
  localparam int unsigned MUL_W      = 59;
  localparam int unsigned SPLIT_W    = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  // A column is below 77 * 2^108 plus one 64-bit carry, so 115 bits hold it exactly.
  localparam int unsigned COL_W      = 115;
  localparam int unsigned CARRY_W    = 64;
  localparam int unsigned FOLD       = 19;
  // Input stage, two multiplier stages, column stage, three reduction stages.
  localparam int unsigned NUM_STAGES = 7;

  typedef logic [LIMB_IN_W-1:0] limb_in_t;
  typedef logic [LIMB_W-1:0]    limb_t;
  typedef logic [LIMB1_W-1:0]   limb1_t;
  typedef logic [MUL_W-1:0]     mul_op_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [CARRY_W-1:0]   carry_t;

endpackage

// ----- rtl/fsq_if.sv -----
// Request and result channel interfaces of the field squaring pipeline.
// Depends on fsq_pkg for the limb types.
interface fsq_in_if;
  logic             valid;
  logic             ready;
  fsq_pkg::limb_in_t in_limb_0;
  fsq_pkg::limb_in_t in_limb_1;
  fsq_pkg::limb_in_t in_limb_2;
  fsq_pkg::limb_in_t in_limb_3;
  fsq_pkg::limb_in_t in_limb_4;

  modport source (output valid, in_limb_0, in_limb_1, in_limb_2, in_limb_3, in_limb_4,
                  input ready);
  modport sink   (input valid, in_limb_0, in_limb_1, in_limb_2, in_limb_3, in_limb_4,
                  output ready);
endinterface

interface fsq_out_if;
  logic           valid;
  logic           ready;
  fsq_pkg::limb_t  out_limb_0;
  fsq_pkg::limb1_t out_limb_1;
  fsq_pkg::limb_t  out_limb_2;
  fsq_pkg::limb_t  out_limb_3;
  fsq_pkg::limb_t  out_limb_4;

  modport source (output valid, out_limb_0, out_limb_1, out_limb_2, out_limb_3, out_limb_4,
                  input ready);
  modport sink   (input valid, out_limb_0, out_limb_1, out_limb_2, out_limb_3, out_limb_4,
                  output ready);
endinterface

// ----- rtl/fsq_mul.sv -----
// Two-stage pipelined wide multiplier built from four narrow partial products.
// Depends on fsq_pkg for the default widths.
module fsq_mul #(
  parameter int unsigned OpW    = fsq_pkg::MUL_W,
  parameter int unsigned SplitW = fsq_pkg::SPLIT_W
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [OpW-1:0]    a_i,
  input  logic [OpW-1:0]    b_i,
  output logic [2*OpW-1:0]  p_o
);

  localparam int unsigned HiW = OpW - SplitW;

  logic [2*SplitW-1:0]   ll_d, ll_q;
  logic [SplitW+HiW-1:0] lh_d, lh_q, hl_d, hl_q;
  logic [2*HiW-1:0]      hh_d, hh_q;
  logic [2*OpW-1:0]      p_d, p_q;

  always_comb begin
    ll_d = (2*SplitW)'(a_i[SplitW-1:0]) * (2*SplitW)'(b_i[SplitW-1:0]);
    lh_d = (SplitW+HiW)'(a_i[SplitW-1:0]) * (SplitW+HiW)'(b_i[OpW-1:SplitW]);
    hl_d = (SplitW+HiW)'(a_i[OpW-1:SplitW]) * (SplitW+HiW)'(b_i[SplitW-1:0]);
    hh_d = (2*HiW)'(a_i[OpW-1:SplitW]) * (2*HiW)'(b_i[OpW-1:SplitW]);
  end

  assign p_d = (2*OpW)'(ll_q)
             + ((2*OpW)'(lh_q) << SplitW)
             + ((2*OpW)'(hl_q) << SplitW)
             + ((2*OpW)'(hh_q) << (2*SplitW));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/fsq_reduce.sv -----
// Three-stage carry chain: splits the five columns into 51-bit limbs and
// folds the top carry times 19 into limb 0. Depends on fsq_pkg.
module fsq_reduce (
  input  logic            clk_i,
  input  logic            en_i,
  input  fsq_pkg::col_t   col_i [fsq_pkg::NUM_LIMBS],
  output fsq_pkg::limb_t  limb0_o,
  output fsq_pkg::limb1_t limb1_o,
  output fsq_pkg::limb_t  limb2_o,
  output fsq_pkg::limb_t  limb3_o,
  output fsq_pkg::limb_t  limb4_o
);

  localparam int unsigned LW = fsq_pkg::LIMB_W;
  localparam int unsigned CT = fsq_pkg::LIMB_W + fsq_pkg::CARRY_W - 1;

  // First stage: columns 1 and 2 absorb their carries.
  fsq_pkg::col_t   x1, x2_d, x2_q, col3_q, col4_q;
  fsq_pkg::limb_t  r0a_q, r1a_q;
  // Second stage: columns 3 and 4.
  fsq_pkg::col_t   x3, x4;
  fsq_pkg::limb_t  r0b_q, r1b_q, r2_q, r3_q, r4_q;
  fsq_pkg::carry_t cy_d, cy_q;
  // Third stage: fold.
  fsq_pkg::carry_t cy19, f;
  fsq_pkg::limb_t  out0_d, out0_q, out2_q, out3_q, out4_q;
  fsq_pkg::limb1_t out1_d, out1_q;

  // Carries are truncated to 64 bits, as the column split defines them.
  assign x1   = col_i[1] + fsq_pkg::COL_W'(col_i[0][CT:LW]);
  assign x2_d = col_i[2] + fsq_pkg::COL_W'(x1[CT:LW]);

  assign x3   = col3_q + fsq_pkg::COL_W'(x2_q[CT:LW]);
  assign x4   = col4_q + fsq_pkg::COL_W'(x3[CT:LW]);
  assign cy_d = x4[CT:LW];

  // The fold wraps at 64 bits.
  assign cy19   = (cy_q << 4) + (cy_q << 1) + cy_q;
  assign f      = fsq_pkg::CARRY_W'(r0b_q) + cy19;
  assign out0_d = f[LW-1:0];
  assign out1_d = fsq_pkg::LIMB1_W'(r1b_q) + fsq_pkg::LIMB1_W'(f[fsq_pkg::CARRY_W-1:LW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0a_q  <= col_i[0][LW-1:0];
      r1a_q  <= x1[LW-1:0];
      x2_q   <= x2_d;
      col3_q <= col_i[3];
      col4_q <= col_i[4];

      r0b_q  <= r0a_q;
      r1b_q  <= r1a_q;
      r2_q   <= x2_q[LW-1:0];
      r3_q   <= x3[LW-1:0];
      r4_q   <= x4[LW-1:0];
      cy_q   <= cy_d;

      out0_q <= out0_d;
      out1_q <= out1_d;
      out2_q <= r2_q;
      out3_q <= r3_q;
      out4_q <= r4_q;
    end
  end

  assign limb0_o = out0_q;
  assign limb1_o = out1_q;
  assign limb2_o = out2_q;
  assign limb3_o = out3_q;
  assign limb4_o = out4_q;

endmodule

// ----- rtl/field_square_p25519_radix51.sv -----
// Top level of the pipelined squaring modulo 2^255 - 19 in radix 2^51.
// Depends on fsq_pkg, fsq_if (channels), fsq_mul and fsq_reduce.
//
//   Port      Direction  Handshake      Payload
//   sq_in_i   request    valid / ready  in_limb_0 .. in_limb_4  (54 bits each)
//   sq_out_o  result     valid / ready  out_limb_0 .. out_limb_4 (51, 52, 51, 51, 51)
//
// One request enters per cycle while no result is stalled; its result appears once it
// has passed all the stages: input and times-19 operands, partial products, product sums,
// column sums, and three carry-chain stages; the last one is the output register.
// Reset clears only the stage valid bits. While the result is held and not taken,
// the whole pipeline freezes and the request side sees ready low; nothing is lost.
module field_square_p25519_radix51 #(
  parameter int unsigned SplitW = fsq_pkg::SPLIT_W
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsq_in_if.sink     sq_in_i,
  fsq_out_if.source  sq_out_o
);

  localparam int unsigned NS = fsq_pkg::NUM_STAGES;
  localparam int unsigned NL = fsq_pkg::NUM_LIMBS;
  localparam int unsigned NP = fsq_pkg::NUM_PRODS;

  logic                 adv;
  logic [NS-1:0]        vld_d, vld_q;

  fsq_pkg::limb_in_t    a_q [NL];
  fsq_pkg::mul_op_t     n3_d, n3_q, n4_d, n4_q;
  fsq_pkg::mul_op_t     ax  [NL];
  fsq_pkg::mul_op_t     mul_a [NP];
  fsq_pkg::mul_op_t     mul_b [NP];
  fsq_pkg::prod_t       prod  [NP];
  fsq_pkg::col_t        pc    [NP];
  fsq_pkg::col_t        col_d [NL];
  fsq_pkg::col_t        col_q [NL];

  // The pipeline moves as one unless a finished result is waiting.
  assign adv           = !vld_q[NS-1] || sq_out_o.ready;
  assign sq_in_i.ready = adv;

  assign vld_d = {vld_q[NS-2:0], sq_in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: capture the limbs and build 19 * a3 and 19 * a4.
  assign n3_d = (fsq_pkg::MUL_W'(sq_in_i.in_limb_3) << 4)
              + (fsq_pkg::MUL_W'(sq_in_i.in_limb_3) << 1)
              + fsq_pkg::MUL_W'(sq_in_i.in_limb_3);
  assign n4_d = (fsq_pkg::MUL_W'(sq_in_i.in_limb_4) << 4)
              + (fsq_pkg::MUL_W'(sq_in_i.in_limb_4) << 1)
              + fsq_pkg::MUL_W'(sq_in_i.in_limb_4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q[0] <= sq_in_i.in_limb_0;
      a_q[1] <= sq_in_i.in_limb_1;
      a_q[2] <= sq_in_i.in_limb_2;
      a_q[3] <= sq_in_i.in_limb_3;
      a_q[4] <= sq_in_i.in_limb_4;
      n3_q   <= n3_d;
      n4_q   <= n4_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ax[i] = fsq_pkg::MUL_W'(a_q[i]);
    end
  end

  // Product k belongs to column k / 3. Doubling of cross terms is applied
  // as a shift when the columns are summed.
  always_comb begin
    mul_a[0]  = ax[0]; mul_b[0]  = ax[0];
    mul_a[1]  = ax[1]; mul_b[1]  = n4_q;
    mul_a[2]  = ax[2]; mul_b[2]  = n3_q;
    mul_a[3]  = ax[0]; mul_b[3]  = ax[1];
    mul_a[4]  = n3_q;  mul_b[4]  = ax[3];
    mul_a[5]  = ax[2]; mul_b[5]  = n4_q;
    mul_a[6]  = ax[0]; mul_b[6]  = ax[2];
    mul_a[7]  = ax[1]; mul_b[7]  = ax[1];
    mul_a[8]  = ax[3]; mul_b[8]  = n4_q;
    mul_a[9]  = ax[0]; mul_b[9]  = ax[3];
    mul_a[10] = ax[1]; mul_b[10] = ax[2];
    mul_a[11] = n4_q;  mul_b[11] = ax[4];
    mul_a[12] = ax[0]; mul_b[12] = ax[4];
    mul_a[13] = ax[1]; mul_b[13] = ax[3];
    mul_a[14] = ax[2]; mul_b[14] = ax[2];
  end

  // Stages 2 and 3: fifteen pipelined products.
  for (genvar k = 0; k < NP; k++) begin : g_mul
    fsq_mul #(
      .OpW    (fsq_pkg::MUL_W),
      .SplitW (SplitW)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (mul_a[k]),
      .b_i   (mul_b[k]),
      .p_o   (prod[k])
    );
    // Every product is below 2^114, so the truncation keeps all bits.
    assign pc[k] = fsq_pkg::COL_W'(prod[k]);
  end

  // Stage 4: column sums.
  assign col_d[0] = pc[0]         + (pc[1] << 1)  + (pc[2] << 1);
  assign col_d[1] = (pc[3] << 1)  + pc[4]         + (pc[5] << 1);
  assign col_d[2] = (pc[6] << 1)  + pc[7]         + (pc[8] << 1);
  assign col_d[3] = (pc[9] << 1)  + (pc[10] << 1) + pc[11];
  assign col_d[4] = (pc[12] << 1) + (pc[13] << 1) + pc[14];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q <= col_d;
    end
  end

  // Stages 5 to 7: carry chain and fold.
  fsq_reduce u_reduce (
    .clk_i   (clk_i),
    .en_i    (adv),
    .col_i   (col_q),
    .limb0_o (sq_out_o.out_limb_0),
    .limb1_o (sq_out_o.out_limb_1),
    .limb2_o (sq_out_o.out_limb_2),
    .limb3_o (sq_out_o.out_limb_3),
    .limb4_o (sq_out_o.out_limb_4)
  );

  assign sq_out_o.valid = vld_q[NS-1];

  // A waiting result must hold off new requests.
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_out_o.valid && !sq_out_o.ready) |-> !sq_in_i.ready)
    else $error("request taken while a result is stalled");

  // An accepted request occupies the first stage in the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_in_i.valid && sq_in_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // The final carry into limb 1 is at most 13 bits, so limb 1 stays below 2^51 + 2^13.
  a_limb1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_out_o.valid |-> !(sq_out_o.out_limb_1[fsq_pkg::LIMB1_W-1]
                         && (|sq_out_o.out_limb_1[fsq_pkg::LIMB_W-1:13])))
    else $error("limb 1 exceeds its bound");

endmodule
